// ----- sv/ttrc_pkg.sv -----
// Shared constants and the modulo-65535 fold for the three-term recurrence checksum.
// No dependencies; used by ttrc_term and three_term_recurrence_checksum_core.
`default_nettype none

package ttrc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TERM_W = 16;
  localparam int unsigned PLUS_W = 25;   // (byte + alpha) * curr, 9 x 16 bits
  localparam int unsigned MINUS_W = 24;  // beta * prev, 8 x 16 bits

  localparam logic [BYTE_W-1:0] FIRST_OFFSET = 8'd7;
  localparam logic [BYTE_W-1:0] ALPHA_MULT = 8'd17;
  localparam logic [BYTE_W-1:0] BETA_MULT = 8'd31;
  localparam logic [TERM_W-1:0] MODULUS = 16'hFFFF;
  localparam logic [TERM_W-1:0] TERM_RESET = 16'd1;

  // 2^16 == 1 mod 65535: fold the high bits onto the low half twice.
  function automatic logic [TERM_W-1:0] mod_m(input logic [PLUS_W-1:0] x);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, x[15:0]} + {8'b0, x[24:16]};
    s2 = {1'b0, s1[15:0]} + {16'b0, s1[16]};
    return (s2[15:0] == MODULUS) ? '0 : s2[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/three_term_recurrence_checksum_core.sv -----
// Three-term recurrence checksum core: byte stream in, one checksum per message out.
// The last byte is held in the input register, then the recurrence update loads the output
// register when it is empty or being read. Throughput: one byte per cycle, unless an unread
// checksum stalls a last byte; set by the combinational multiply-subtract-fold loop on curr/prev.
// Reset (rst, synchronous): terms to 1, position 0, awaiting the first byte, no output.
// Depends on ttrc_pkg and ttrc_term.
`default_nettype none

module three_term_recurrence_checksum_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // [15:0] checksum
);

  // input register
  logic v1;
  logic l1;
  logic [ttrc_pkg::BYTE_W-1:0] b1;

  // recurrence state
  logic [ttrc_pkg::TERM_W-1:0] curr;
  logic [ttrc_pkg::TERM_W-1:0] prev;
  logic [ttrc_pkg::BYTE_W-1:0] pos;
  logic in_msg;

  logic adv;
  logic [ttrc_pkg::TERM_W-1:0] term;
  logic [ttrc_pkg::TERM_W-1:0] curr_next;

  assign adv = v1 && (!l1 || !m_tvalid || m_tready);
  assign s_tready = !v1 || adv;

  ttrc_term u_term (
    .data_byte(b1),
    .pos(pos),
    .curr(curr),
    .prev(prev),
    .term(term)
  );

  assign curr_next = in_msg ? term : (16'(b1) + 16'(ttrc_pkg::FIRST_OFFSET));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      v1 <= 1'b1;
    end else if (adv) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      b1 <= s_tdata;
      l1 <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curr <= ttrc_pkg::TERM_RESET;
      prev <= ttrc_pkg::TERM_RESET;
      pos <= '0;
      in_msg <= 1'b0;
    end else if (adv) begin
      if (l1) begin
        curr <= ttrc_pkg::TERM_RESET;
        prev <= ttrc_pkg::TERM_RESET;
        pos <= '0;
        in_msg <= 1'b0;
      end else begin
        curr <= curr_next;
        prev <= in_msg ? curr : ttrc_pkg::TERM_RESET;
        pos <= pos + 8'd1;
        in_msg <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && l1) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && l1) begin
      m_tdata <= curr_next;
    end
  end

  // checks
  a_rearm: assert property (@(posedge clk) disable iff (rst) adv && l1 |=> !in_msg)
    else $error("not rearmed after last byte");
  a_pos_idle: assert property (@(posedge clk) disable iff (rst) !in_msg |-> pos == 8'd0)
    else $error("position nonzero while awaiting first byte");
  a_term_range: assert property (@(posedge clk) disable iff (rst)
      in_msg |-> curr != ttrc_pkg::MODULUS)
    else $error("term out of range");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
      $rose(m_tvalid) |-> $past(adv && l1))
    else $error("checksum without last byte");

endmodule

`default_nettype wire

// ----- sv/ttrc_term.sv -----
// Next-term logic of the recurrence: ((byte + alpha) * curr - beta * prev) mod 65535,
// with a negative difference of magnitude d mapped to (1 - d) mod 65535. Depends on ttrc_pkg.
`default_nettype none

module ttrc_term (
  input  wire logic [ttrc_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [ttrc_pkg::BYTE_W-1:0] pos,
  input  wire logic [ttrc_pkg::TERM_W-1:0] curr,
  input  wire logic [ttrc_pkg::TERM_W-1:0] prev,
  output logic      [ttrc_pkg::TERM_W-1:0] term
);

  logic [ttrc_pkg::BYTE_W-1:0] alpha;
  logic [ttrc_pkg::BYTE_W-1:0] beta;
  logic [ttrc_pkg::BYTE_W:0] weight;
  logic [ttrc_pkg::PLUS_W-1:0] plus;
  logic [ttrc_pkg::MINUS_W-1:0] minus;
  logic [ttrc_pkg::PLUS_W-1:0] minus_ext;
  logic neg;
  logic [ttrc_pkg::PLUS_W-1:0] mag;
  logic [ttrc_pkg::TERM_W-1:0] m;

  assign alpha = 8'(pos * ttrc_pkg::ALPHA_MULT);
  assign beta = 8'(pos * ttrc_pkg::BETA_MULT);
  assign weight = {1'b0, data_byte} + {1'b0, alpha};
  assign plus = 25'(weight) * 25'(curr);
  assign minus = 24'(beta) * 24'(prev);
  assign minus_ext = {1'b0, minus};
  assign neg = plus < minus_ext;
  assign mag = neg ? (minus_ext - plus) : (plus - minus_ext);
  assign m = ttrc_pkg::mod_m(mag);

  always_comb begin
    if (!neg) begin
      term = m;
    end else if (m == 16'd0) begin
      term = 16'd1;
    end else if (m == 16'd1) begin
      term = 16'd0;
    end else begin
      term = 16'(17'h10000 - {1'b0, m});
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/three_term_recurrence_checksum_core_tb.sv -----
// Self-checking bench for three_term_recurrence_checksum_core: byte messages in, one checksum out.
// A scoreboard class predicts each checksum from the accepted bytes and checks every result.
// Depends on ttrc_pkg and the core RTL.
`default_nettype none

module three_term_recurrence_checksum_core_tb;

  localparam int unsigned STALL_PCT = 16;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_BYTES = 600;
  localparam int unsigned WRAP_MSG_LEN = 300;
  localparam int unsigned CALM_START = 150;
  localparam int unsigned CALM_END = 300;

  class recurrence_board;
    logic [ttrc_pkg::TERM_W-1:0] prev_t;
    logic [ttrc_pkg::TERM_W-1:0] curr_t;
    logic [ttrc_pkg::BYTE_W-1:0] pos;
    bit                          in_msg;
    logic [ttrc_pkg::TERM_W-1:0] expected_sums[$];
    int unsigned                 errors;

    function new();
      clear_terms();
      errors = 0;
    endfunction

    function void clear_terms();
      prev_t = ttrc_pkg::TERM_RESET;
      curr_t = ttrc_pkg::TERM_RESET;
      pos = '0;
      in_msg = 1'b0;
    endfunction

    // New term at position pos; a negative difference wraps as (1 - d) mod 65535.
    function logic [ttrc_pkg::TERM_W-1:0] next_term(logic [ttrc_pkg::BYTE_W-1:0] b);
      int unsigned p, alpha, beta, plus, minus, d, m;
      p = pos;
      m = ttrc_pkg::MODULUS;
      alpha = (p * ttrc_pkg::ALPHA_MULT) & 8'hFF;
      beta = (p * ttrc_pkg::BETA_MULT) & 8'hFF;
      plus = (b + alpha) * curr_t;
      minus = beta * prev_t;
      if (plus >= minus) begin
        return ttrc_pkg::TERM_W'((plus - minus) % m);
      end
      d = (minus - plus) % m;
      return ttrc_pkg::TERM_W'((1 + m - d) % m);
    endfunction

    function void note_byte(logic [ttrc_pkg::BYTE_W-1:0] b, logic last);
      logic [ttrc_pkg::TERM_W-1:0] t;
      if (!in_msg) begin
        prev_t = ttrc_pkg::TERM_RESET;
        curr_t = ttrc_pkg::TERM_W'(b) + ttrc_pkg::TERM_W'(ttrc_pkg::FIRST_OFFSET);
        pos = 8'd1;
        in_msg = 1'b1;
      end else begin
        t = next_term(b);
        prev_t = curr_t;
        curr_t = t;
        pos = pos + 8'd1;
      end
      if (last) begin
        expected_sums.push_back(curr_t);
        clear_terms();
      end
    endfunction

    function void check_sum(logic [ttrc_pkg::TERM_W-1:0] actual);
      logic [ttrc_pkg::TERM_W-1:0] want;
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected checksum transfer, expected none, actual %h", $time, actual);
        errors++;
        return;
      end
      want = expected_sums.pop_front();
      if (actual !== want) begin
        $display("%0t: checksum mismatch, expected %h, actual %h", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;

  recurrence_board   board = new();
  int unsigned       sent_bytes = 0;
  int unsigned       quiet_cycles = 0;

  three_term_recurrence_checksum_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit calm();
    return sent_bytes >= CALM_START && sent_bytes < CALM_END;
  endfunction

  // Result side: random stalls outside the calm window, sampled values are those before the edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_sum(m_tdata);
    end
    m_tready <= calm() || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm() && $urandom_range(0, 99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    board.note_byte(b, last);
    sent_bytes++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  initial begin
    int unsigned msg_count;
    int unsigned len;
    msg_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-byte messages at both extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // short messages with extreme and alternating bytes
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hF0, 1'b1);

    while (sent_bytes < RANDOM_BYTES + 13) begin
      if (msg_count == 2) begin
        len = WRAP_MSG_LEN;  // position count wraps past 256
      end else if ($urandom_range(0, 19) == 0) begin
        len = $urandom_range(13, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      send_message(len);
      msg_count++;
    end
    s_tvalid <= 1'b0;

    while (board.expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
